// File: rtl/core/cpe_pkg.sv
// Types and constants shared by the channel plan engine and its checker.
package cpe_pkg;

    localparam int unsigned FREQ_W = 30;
    localparam int unsigned STEP_W = 24;

    localparam int unsigned NARROW_CHANNELS = 64;
    localparam int unsigned FIXED_CHANNELS  = 72;

    localparam logic [4:0] POWER_NARROW_HIGH = 5'd30;
    localparam logic [4:0] POWER_NARROW_LOW  = 5'd21;
    localparam logic [4:0] POWER_WIDE        = 5'd26;
    localparam logic [6:0] HIGH_POWER_MIN    = 7'd50;

    localparam logic [3:0] RX1_LOW_RATES = 4'd4;
    localparam logic [4:0] RX1_RATE_BIAS = 5'd10;
    localparam logic [4:0] RX1_RATE_MIN  = 5'd8;
    localparam logic [4:0] RX1_RATE_MAX  = 5'd13;

    localparam logic [FREQ_W-1:0] RST_UP_NARROW_BASE = 30'd902300000;
    localparam logic [STEP_W-1:0] RST_UP_NARROW_STEP = 24'd200000;
    localparam logic [FREQ_W-1:0] RST_UP_WIDE_BASE   = 30'd903000000;
    localparam logic [STEP_W-1:0] RST_UP_WIDE_STEP   = 24'd1600000;
    localparam logic [FREQ_W-1:0] RST_DOWN_BASE      = 30'd923300000;
    localparam logic [STEP_W-1:0] RST_DOWN_STEP      = 24'd600000;

    typedef enum logic [2:0] {
        CMD_SETUP_EXTRA    = 3'd0,
        CMD_ENABLE         = 3'd1,
        CMD_DISABLE        = 3'd2,
        CMD_ENABLE_SUBBAND = 3'd3,
        CMD_DISABLE_SUBBAND= 3'd4,
        CMD_SELECT_SUBBAND = 3'd5,
        CMD_UPLINK         = 3'd6,
        CMD_RX1            = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        REG_UP_NARROW_BASE = 3'd0,
        REG_UP_NARROW_STEP = 3'd1,
        REG_UP_WIDE_BASE   = 3'd2,
        REG_UP_WIDE_STEP   = 3'd3,
        REG_DOWN_BASE      = 3'd4,
        REG_DOWN_STEP      = 3'd5,
        REG_RX1_RATE_OFS   = 3'd6
    } t_reg;

    typedef struct packed {
        logic [2:0]        command;
        logic [7:0]        channel;
        logic [2:0]        subband;
        logic [FREQ_W-1:0] frequency_in;
        logic [3:0]        uplink_rate;
    } t_in_item;

    typedef struct packed {
        logic              flag;
        logic [FREQ_W-1:0] frequency_out;
        logic [4:0]        tx_power;
        logic [3:0]        down_rate;
        logic [6:0]        active_narrow;
        logic [3:0]        active_wide;
    } t_out_item;

endpackage

// File: rtl/core/channel_plan_engine.sv
// Channel plan engine: enable bits, counts and frequency/power/rate sequencer.
// Set-up, enable, disable, extra or out-of-range uplink: S_EXEC, then S_DONE to the result beat;
// sub-band commands walk the 72 fixed channels one per cycle in S_WALK;
// other uplink and RX1 frequencies go through a shift-add multiplier in S_MUL.
// One item at a time: the next beat is taken once the result is queued out.
// Synchronous active-low reset clears all enable bits, counts, extra frequencies.
module channel_plan_engine #(
    parameter int unsigned EXTRA_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cpe_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cpe_pkg::t_out_item    o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [29:0]           i_cfg_data
);
    import cpe_pkg::*;

    localparam int unsigned TOTAL = FIXED_CHANNELS + EXTRA_CHANNELS;
    localparam int unsigned EW    = $clog2(TOTAL);
    localparam int unsigned XD    = (EXTRA_CHANNELS > 0) ? EXTRA_CHANNELS : 1;
    localparam int unsigned XW    = (XD > 1) ? $clog2(XD) : 1;
    localparam logic [7:0] TOTAL_CH  = 8'(TOTAL);
    localparam logic [7:0] FIXED_CH  = 8'(FIXED_CHANNELS);
    localparam logic [7:0] NARROW_CH = 8'(NARROW_CHANNELS);
    localparam logic [EW-1:0] NARROW_IDX = EW'(NARROW_CHANNELS);
    localparam logic [EW-1:0] FIXED_IDX  = EW'(FIXED_CHANNELS);
    localparam logic [EW-1:0] LAST_FIXED = EW'(FIXED_CHANNELS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_MUL,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [FREQ_W-1:0] r_up_narrow_base, r_up_wide_base, r_down_base;
    logic [STEP_W-1:0] r_up_narrow_step, r_up_wide_step, r_down_step;
    logic [1:0]        r_rx1_ofs;

    // plan state
    logic [TOTAL-1:0]  r_en;
    logic [6:0]        r_narrow_cnt, n_narrow_cnt;
    logic [3:0]        r_wide_cnt, n_wide_cnt;
    logic [FREQ_W-1:0] r_extra_freq [XD];

    // latched item
    t_cmd              r_cmd;
    logic [7:0]        r_ch;
    logic [2:0]        r_band;
    logic [FREQ_W-1:0] r_fin;
    logic [3:0]        r_rate;

    // sequencer and shared shift-add unit
    logic [EW-1:0]     r_idx;
    logic [FREQ_W-1:0] r_acc, r_mcand;
    logic [5:0]        r_mplier;
    logic              r_flag;
    logic [4:0]        r_pow;
    logic [3:0]        r_drate;

    logic              r_out_valid;
    t_out_item         r_out_data;

    // single enable-bit write port
    logic              wr_en, wr_on, wr_changed;
    logic [EW-1:0]     wr_idx;
    logic [2:0]        walk_band;
    logic              walk_match;

    logic              ch_in_range, ch_is_extra;
    logic [XW-1:0]     extra_idx;
    logic [7:0]        ch_less_fixed;
    logic [4:0]        rate_cand, rate_clamped;

    assign ch_in_range   = r_ch < TOTAL_CH;
    assign ch_is_extra   = (r_ch >= FIXED_CH) && ch_in_range;
    assign ch_less_fixed = r_ch - FIXED_CH;
    assign extra_idx     = ch_less_fixed[XW-1:0];

    assign walk_band  = (r_idx < NARROW_IDX) ? r_idx[5:3] : r_idx[2:0];
    assign walk_match = walk_band == r_band;

    always_comb begin
        rate_cand = (r_rate < RX1_LOW_RATES) ? 5'(r_rate) + RX1_RATE_BIAS - 5'(r_rx1_ofs)
                                             : RX1_RATE_MAX - 5'(r_rx1_ofs);
        if (rate_cand < RX1_RATE_MIN) begin
            rate_clamped = RX1_RATE_MIN;
        end else if (rate_cand > RX1_RATE_MAX) begin
            rate_clamped = RX1_RATE_MAX;
        end else begin
            rate_clamped = rate_cand;
        end
    end

    always_comb begin
        wr_en  = 1'b0;
        wr_on  = 1'b0;
        wr_idx = r_ch[EW-1:0];
        case (r_state)
            S_EXEC: begin
                case (r_cmd)
                    CMD_SETUP_EXTRA: begin
                        wr_en = ch_is_extra;
                        wr_on = 1'b1;
                    end
                    CMD_ENABLE: begin
                        wr_en = ch_in_range;
                        wr_on = 1'b1;
                    end
                    CMD_DISABLE: begin
                        wr_en = ch_in_range;
                        wr_on = 1'b0;
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                wr_idx = r_idx;
                case (r_cmd)
                    CMD_ENABLE_SUBBAND: begin
                        wr_en = walk_match;
                        wr_on = 1'b1;
                    end
                    CMD_DISABLE_SUBBAND: begin
                        wr_en = walk_match;
                        wr_on = 1'b0;
                    end
                    default: begin
                        wr_en = 1'b1;
                        wr_on = walk_match;
                    end
                endcase
            end
            default: ;
        endcase
        wr_changed = wr_en && (r_en[wr_idx] != wr_on);

        n_narrow_cnt = r_narrow_cnt;
        n_wide_cnt   = r_wide_cnt;
        if (wr_changed && wr_idx < NARROW_IDX) begin
            n_narrow_cnt = wr_on ? r_narrow_cnt + 7'd1 : r_narrow_cnt - 7'd1;
        end else if (wr_changed && wr_idx < FIXED_IDX) begin
            n_wide_cnt = wr_on ? r_wide_cnt + 4'd1 : r_wide_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_up_narrow_base <= RST_UP_NARROW_BASE;
            r_up_narrow_step <= RST_UP_NARROW_STEP;
            r_up_wide_base   <= RST_UP_WIDE_BASE;
            r_up_wide_step   <= RST_UP_WIDE_STEP;
            r_down_base      <= RST_DOWN_BASE;
            r_down_step      <= RST_DOWN_STEP;
            r_rx1_ofs        <= 2'd0;
            r_en             <= '0;
            r_narrow_cnt     <= '0;
            r_wide_cnt       <= '0;
            for (int i = 0; i < int'(XD); i++) begin
                r_extra_freq[i] <= '0;
            end
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg'(i_cfg_index))
                    REG_UP_NARROW_BASE: r_up_narrow_base <= i_cfg_data;
                    REG_UP_NARROW_STEP: r_up_narrow_step <= i_cfg_data[STEP_W-1:0];
                    REG_UP_WIDE_BASE:   r_up_wide_base   <= i_cfg_data;
                    REG_UP_WIDE_STEP:   r_up_wide_step   <= i_cfg_data[STEP_W-1:0];
                    REG_DOWN_BASE:      r_down_base      <= i_cfg_data;
                    REG_DOWN_STEP:      r_down_step      <= i_cfg_data[STEP_W-1:0];
                    REG_RX1_RATE_OFS:   r_rx1_ofs        <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (wr_en) begin
                r_en[wr_idx] <= wr_on;
            end
            r_narrow_cnt <= n_narrow_cnt;
            r_wide_cnt   <= n_wide_cnt;

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= t_cmd'(i_in_data.command);
                        r_ch    <= i_in_data.channel;
                        r_band  <= i_in_data.subband;
                        r_fin   <= i_in_data.frequency_in;
                        r_rate  <= i_in_data.uplink_rate;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_flag   <= wr_changed;
                    r_acc    <= '0;
                    r_pow    <= '0;
                    r_drate  <= '0;
                    r_mplier <= '0;
                    r_idx    <= '0;
                    r_state  <= S_DONE;
                    case (r_cmd)
                        CMD_SETUP_EXTRA: begin
                            r_flag <= ch_is_extra;
                            if (ch_is_extra) begin
                                r_extra_freq[extra_idx] <= r_fin;
                            end
                        end
                        CMD_ENABLE_SUBBAND, CMD_DISABLE_SUBBAND, CMD_SELECT_SUBBAND: begin
                            r_flag  <= 1'b0;
                            r_state <= S_WALK;
                        end
                        CMD_UPLINK: begin
                            r_flag <= ch_in_range;
                            if (r_ch < NARROW_CH) begin
                                r_acc    <= r_up_narrow_base;
                                r_mcand  <= FREQ_W'(r_up_narrow_step);
                                r_mplier <= r_ch[5:0];
                                r_pow    <= (r_narrow_cnt >= HIGH_POWER_MIN) ?
                                            POWER_NARROW_HIGH : POWER_NARROW_LOW;
                                r_state  <= S_MUL;
                            end else if (r_ch < FIXED_CH) begin
                                r_acc    <= r_up_wide_base;
                                r_mcand  <= FREQ_W'(r_up_wide_step);
                                r_mplier <= {3'd0, r_ch[2:0]};
                                r_pow    <= POWER_WIDE;
                                r_state  <= S_MUL;
                            end else if (ch_in_range) begin
                                r_acc <= r_extra_freq[extra_idx];
                                r_pow <= POWER_WIDE;
                            end
                        end
                        CMD_RX1: begin
                            r_flag   <= 1'b1;
                            r_acc    <= r_down_base;
                            r_mcand  <= FREQ_W'(r_down_step);
                            r_mplier <= {3'd0, r_ch[2:0]};
                            r_drate  <= rate_clamped[3:0];
                            r_state  <= S_MUL;
                        end
                        default: ;
                    endcase
                end
                S_WALK: begin
                    r_flag <= r_flag | wr_changed;
                    r_idx  <= r_idx + EW'(1);
                    if (r_idx == LAST_FIXED) begin
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    // one partial product per cycle, wraps mod 2^30
                    if (r_mplier == 6'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_mplier[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand  <= {r_mcand[FREQ_W-2:0], 1'b0};
                        r_mplier <= {1'b0, r_mplier[5:1]};
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid                <= 1'b1;
                        r_out_data.flag            <= r_flag;
                        r_out_data.frequency_out   <= r_acc;
                        r_out_data.tx_power        <= r_pow;
                        r_out_data.down_rate       <= r_drate;
                        r_out_data.active_narrow   <= r_narrow_cnt;
                        r_out_data.active_wide     <= r_wide_cnt;
                        r_state                    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// File: rtl/core/cpe_check.sv
// Port-level assertions for the channel plan engine, bound into the channel plan engine.
module cpe_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cpe_pkg::t_out_item o_out_data
);
    import cpe_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one item at a time: the sequencer is busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice in a row");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.active_narrow <= 7'd64 && o_out_data.active_wide <= 4'd8)
        else $error("channel count out of range");

    a_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.tx_power == 5'd0 ||
                        o_out_data.tx_power == POWER_NARROW_LOW ||
                        o_out_data.tx_power == POWER_WIDE ||
                        o_out_data.tx_power == POWER_NARROW_HIGH)
        else $error("bad tx power");

    a_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.down_rate == 4'd0 ||
                        (o_out_data.down_rate >= 4'd8 && o_out_data.down_rate <= 4'd13))
        else $error("downlink rate outside clamp");

endmodule

bind channel_plan_engine cpe_check u_cpe_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
